// File: src/ptst_pkg.sv
// ============================================================================
// ptst_pkg
// Shared constants, codes and types of the periodic timer slot table.
// ============================================================================
`default_nettype none

package ptst_pkg;

    localparam int SLOTS    = 32;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HANDLE_W = 6;
    localparam int OP_W     = 2;
    localparam int OWNER_W  = 16;
    localparam int WORD_W   = 32;
    localparam int TICK_W   = 16;
    localparam int PROD_W   = WORD_W + TICK_W;

    localparam logic [TICK_W-1:0] TICK_LENGTH_RESET = TICK_W'(100);

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;

    // result kinds
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // configuration register indexes
    localparam logic REG_TICK_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREATE,
        ST_SCAN,
        ST_DRAIN
    } ptst_state_t;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [OWNER_W-1:0]  owner;
        logic [WORD_W-1:0]   period;
        logic [WORD_W-1:0]   message_word;
        logic [HANDLE_W-1:0] slot_handle;
    } ptst_cmd_t;

    typedef struct packed {
        logic                strobe;
        logic                kind;
        logic [HANDLE_W-1:0] slot;
        logic [OWNER_W-1:0]  owner_out;
        logic [WORD_W-1:0]   value;
        logic                last;
    } ptst_res_t;

    // one-based handle of a slot index, masked to the handle width
    function automatic logic [HANDLE_W-1:0] handle_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] h;
        h = {1'b0, idx} + (IDX_W+1)'(1);
        return HANDLE_W'(h);
    endfunction

endpackage : ptst_pkg

`default_nettype wire

// File: src/ptst_engine.sv
// ============================================================================
// ptst_engine
// Slot store and sequencer: create search, destroy, and pipelined tick walk.
// ============================================================================
`default_nettype none

module ptst_engine
    import ptst_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire ptst_cmd_t         cmd,
    input  wire logic [TICK_W-1:0] tick_length,
    output logic                   busy,
    output ptst_res_t              res
);

    ptst_state_t state_reg, state_next;

    ptst_cmd_t              cmd_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [SLOTS-1:0]       active_reg;

    // slot memories
    logic [OWNER_W-1:0] owner_mem  [SLOTS];
    logic [WORD_W-1:0]  period_mem [SLOTS];
    logic [WORD_W-1:0]  count_mem  [SLOTS];
    logic [WORD_W-1:0]  word_mem   [SLOTS];

    // stage 1: registered memory reads
    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [OWNER_W-1:0] owner_rd;
    logic [WORD_W-1:0]  period_rd;
    logic [WORD_W-1:0]  count_rd;
    logic [WORD_W-1:0]  word_rd;

    // stage 2: product and compare
    logic               s2_valid_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [OWNER_W-1:0] s2_owner_reg;
    logic [WORD_W-1:0]  s2_period_reg;
    logic [WORD_W-1:0]  s2_count_reg;
    logic [WORD_W-1:0]  s2_word_reg;

    // one expiry held back until it is known whether it is the final one
    logic                pend_valid_reg, pend_valid_next;
    logic [HANDLE_W-1:0] pend_slot_reg,  pend_slot_next;
    logic [OWNER_W-1:0]  pend_owner_reg, pend_owner_next;
    logic [WORD_W-1:0]   pend_value_reg, pend_value_next;

    ptst_res_t res_reg, res_next;

    logic               found;
    logic               idx_last;
    logic               pipe_empty;
    logic               scan_issue;
    logic               create_write;
    logic               create_reply;
    logic               flush;
    logic               idx_advance;
    logic               expire;
    logic [PROD_W-1:0]  prod;
    logic               count_we;
    logic [IDX_W-1:0]   count_waddr;
    logic [WORD_W-1:0]  count_wdata;
    logic               destroy_hit;
    logic [IDX_W-1:0]   destroy_idx;

    assign found      = !active_reg[idx_reg];
    assign idx_last   = (idx_reg == IDX_W'(SLOTS - 1));
    assign pipe_empty = !s1_valid_reg && !s2_valid_reg;
    assign busy       = (state_reg != ST_IDLE);

    assign destroy_hit = accept && (cmd.operation == OP_DESTROY)
                         && (cmd.slot_handle != '0)
                         && (32'(cmd.slot_handle) <= 32'(SLOTS));
    assign destroy_idx = IDX_W'(cmd.slot_handle - HANDLE_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.operation)
                        OP_TICK:   state_next = ST_SCAN;
                        OP_CREATE: state_next = ST_CREATE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CREATE:
            begin
                if (found || idx_last)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (idx_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer controls
    always_comb
    begin
        scan_issue   = 1'b0;
        create_write = 1'b0;
        create_reply = 1'b0;
        flush        = 1'b0;
        idx_advance  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_CREATE:
            begin
                create_write = found;
                create_reply = found || idx_last;
                idx_advance  = !found && !idx_last;
            end
            ST_SCAN:
            begin
                scan_issue  = 1'b1;
                idx_advance = !idx_last;
            end
            ST_DRAIN:
            begin
                flush = pipe_empty;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (accept)
            idx_reg <= '0;
        else if (idx_advance)
            idx_reg <= idx_reg + IDX_W'(1);
    end

    // active slots: owner nonzero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (destroy_hit)
            active_reg[destroy_idx] <= 1'b0;
        else if (create_write)
            active_reg[idx_reg] <= (cmd_reg.owner != '0);
    end

    // count write port: create clears, tick writes back
    assign expire      = s2_valid_reg && (prod_reg >= PROD_W'(s2_period_reg));
    assign count_we    = create_write || s2_valid_reg;
    assign count_waddr = create_write ? idx_reg : s2_idx_reg;
    assign count_wdata = create_write ? '0
                       : (expire ? WORD_W'(1) : s2_count_reg + WORD_W'(1));

    always_ff @(posedge clk)
    begin
        if (create_write)
        begin
            owner_mem[idx_reg]  <= cmd_reg.owner;
            period_mem[idx_reg] <= cmd_reg.period;
            word_mem[idx_reg]   <= cmd_reg.message_word;
        end
        if (count_we)
            count_mem[count_waddr] <= count_wdata;
        owner_rd  <= owner_mem[idx_reg];
        period_rd <= period_mem[idx_reg];
        count_rd  <= count_mem[idx_reg];
        word_rd   <= word_mem[idx_reg];
    end

    assign prod = PROD_W'(count_rd) * PROD_W'(tick_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= scan_issue && active_reg[idx_reg];
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg    <= idx_reg;
        s2_idx_reg    <= s1_idx_reg;
        prod_reg      <= prod;
        s2_owner_reg  <= owner_rd;
        s2_period_reg <= period_rd;
        s2_count_reg  <= count_rd;
        s2_word_reg   <= word_rd;
    end

    // result sequencing
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_owner_next = pend_owner_reg;
        pend_value_next = pend_value_reg;
        res_next        = res_reg;
        res_next.strobe = 1'b0;

        if (create_reply)
        begin
            res_next.strobe    = 1'b1;
            res_next.kind      = KIND_REPLY;
            res_next.slot      = found ? handle_of(idx_reg) : '0;
            res_next.owner_out = '0;
            res_next.value     = '0;
            res_next.last      = 1'b1;
        end

        if (expire)
        begin
            if (pend_valid_reg)
            begin
                res_next.strobe    = 1'b1;
                res_next.kind      = KIND_EXPIRY;
                res_next.slot      = pend_slot_reg;
                res_next.owner_out = pend_owner_reg;
                res_next.value     = pend_value_reg;
                res_next.last      = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = handle_of(s2_idx_reg);
            pend_owner_next = s2_owner_reg;
            pend_value_next = (s2_word_reg != '0) ? s2_word_reg : s2_count_reg;
        end

        if (flush && pend_valid_reg)
        begin
            res_next.strobe    = 1'b1;
            res_next.kind      = KIND_EXPIRY;
            res_next.slot      = pend_slot_reg;
            res_next.owner_out = pend_owner_reg;
            res_next.value     = pend_value_reg;
            res_next.last      = 1'b1;
            pend_valid_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg     <= pend_slot_next;
        pend_owner_reg    <= pend_owner_next;
        pend_value_reg    <= pend_value_next;
    end

    assign res = res_reg;

endmodule : ptst_engine

`default_nettype wire

// File: src/periodic_timer_slot_table_top.sv
// ============================================================================
// periodic_timer_slot_table_top
// Periodic timer slot table with command port, result strobe and APB port.
// ============================================================================
// Usage:
//   Present an item on operation/owner/period/message_word/slot_handle and
//   raise start; the item is taken at the edge where start is high and busy
//   is low. Results appear on kind/slot/owner_out/value/last for one cycle
//   each, marked by strobe; last marks the final result of an item.
//   Per operation:
//   - destroy: busy stays low, no result.
//   - create: busy while the free-slot search steps through the active
//     bits one slot a cycle; the reply strobes in the first cycle with
//     busy low.
//   - tick: busy while the walk goes through the slot memories one slot a
//     cycle and the read and multiply stages drain. Each expiry is held
//     until the next expiry or the end of the walk shows whether it is the
//     final one, so it passes the read, product and hold registers before
//     it strobes; the final one strobes in the first cycle with busy low.
//   - unused operation code: ignored, no result.
//   The receiver cannot stall; every strobe is one result.
//   Reset leaves all slots free and the tick length at 100 ms.
//   tick_length_ms sits at byte address 0; write it only while idle, as the block does not enforce this.
// ============================================================================
`default_nettype none

module periodic_timer_slot_table_top
    import ptst_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // command channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [OWNER_W-1:0]  owner,
    input  wire logic [WORD_W-1:0]   period,
    input  wire logic [WORD_W-1:0]   message_word,
    input  wire logic [HANDLE_W-1:0] slot_handle,
    // result channel
    output logic                     strobe,
    output logic                     kind,
    output logic [HANDLE_W-1:0]      slot,
    output logic [OWNER_W-1:0]       owner_out,
    output logic [WORD_W-1:0]        value,
    output logic                     last,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [TICK_W-1:0] tick_length_reg;
    logic              cfg_write;
    logic              accept;
    ptst_cmd_t         cmd;
    ptst_res_t         res;

    // Take an item only when the sequencer is idle.
    assign accept = start && !busy;

    assign cmd.operation    = operation;
    assign cmd.owner        = owner;
    assign cmd.period       = period;
    assign cmd.message_word = message_word;
    assign cmd.slot_handle  = slot_handle;

    // Register access: zero wait states; paddr[2] selects the register word.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_length_reg <= TICK_LENGTH_RESET;
        else if (cfg_write && (paddr[2] == REG_TICK_LENGTH))
            tick_length_reg <= pwdata[TICK_W-1:0];
    end

    // Hold the read data at zero for addresses beyond the register list.
    always_comb
    begin
        unique case (paddr[2])
            REG_TICK_LENGTH: prdata = 32'(tick_length_reg);
            default:         prdata = '0;
        endcase
    end

    ptst_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .tick_length (tick_length_reg),
        .busy        (busy),
        .res         (res)
    );

    // Results leave straight from the engine's output register.
    assign strobe    = res.strobe;
    assign kind      = res.kind;
    assign slot      = res.slot;
    assign owner_out = res.owner_out;
    assign value     = res.value;
    assign last      = res.last;

endmodule : periodic_timer_slot_table_top

`default_nettype wire

// File: src/ptst_checker.sv
// ============================================================================
// ptst_checker
// Port-level checks of the periodic timer slot table, bound to the top level.
// ============================================================================
`default_nettype none

module ptst_checker
    import ptst_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [OP_W-1:0]     operation,
    input wire logic                strobe,
    input wire logic                kind,
    input wire logic [HANDLE_W-1:0] slot,
    input wire logic [OWNER_W-1:0]  owner_out,
    input wire logic [WORD_W-1:0]   value,
    input wire logic                last
);

    // a create reply is always the only result of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_REPLY) |-> last && (owner_out == '0) && (value == '0))
        else $error("create reply malformed");

    // an expiry names a real slot
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_EXPIRY) |-> (slot != '0))
        else $error("expiry without slot handle");

    // more results are due: the item must still be in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("non-final result while idle");

    // a destroy gives no result and leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_DESTROY) |=> !strobe && !busy)
        else $error("destroy produced a result or stalled");

endmodule : ptst_checker

bind periodic_timer_slot_table_top ptst_checker u_ptst_checker (.*);

`default_nettype wire

// File: tb/periodic_timer_slot_table_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// periodic_timer_slot_table_top_test
// Drives create, destroy and tick items and tick-length writes into the timer
// slot table. A software copy of the table predicts every create reply and
// expiry, and each strobed result is checked against the oldest one due.
// ============================================================================

module periodic_timer_slot_table_top_test;
    import ptst_pkg::*;

    // spare operation code, which the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 300000;
    // wait after the due results so that a tick can finish and go idle
    localparam int SETTLE_CYCLES = 48;
    localparam int REPORT_MAX    = 10;

    // ------------------------------------------------------------------------
    // Slot table tracker: mirrors the table and holds the results still due
    // ------------------------------------------------------------------------
    class slot_table_tracker;
        logic [TICK_W-1:0]  tick_ms;
        logic [OWNER_W-1:0] owner_of  [SLOTS];
        logic [WORD_W-1:0]  period_of [SLOTS];
        logic [WORD_W-1:0]  count_of  [SLOTS];
        logic [WORD_W-1:0]  word_of   [SLOTS];
        ptst_res_t          due_results[$];
        int                 mismatches;

        function new();
            tick_ms    = TICK_LENGTH_RESET;
            mismatches = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                owner_of[i]  = '0;
                period_of[i] = '0;
                count_of[i]  = '0;
                word_of[i]   = '0;
            end
        endfunction

        function void set_tick(input logic [TICK_W-1:0] ms);
            tick_ms = ms;
        endfunction

        // work out the results of one accepted item and advance the table
        function void note_item(input ptst_cmd_t c);
            ptst_res_t         fired[$];
            ptst_res_t         r;
            logic [PROD_W-1:0] product;
            int                got;
            r        = '0;
            r.strobe = 1'b1;
            got      = 0;
            case (c.operation)
                OP_TICK:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (owner_of[i] != '0)
                        begin
                            product = PROD_W'(count_of[i]) * PROD_W'(tick_ms);
                            if (product >= PROD_W'(period_of[i]))
                            begin
                                r.kind      = KIND_EXPIRY;
                                r.slot      = HANDLE_W'(i + 1);
                                r.owner_out = owner_of[i];
                                r.value     = (word_of[i] != '0) ? word_of[i] : count_of[i];
                                fired.push_back(r);
                                count_of[i] = '0;
                            end
                            count_of[i] = count_of[i] + 1'b1;
                        end
                    end
                    foreach (fired[k])
                    begin
                        r      = fired[k];
                        r.last = (k == fired.size() - 1);
                        due_results.push_back(r);
                    end
                end
                OP_CREATE:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (got == 0 && owner_of[i] == '0)
                        begin
                            owner_of[i]  = c.owner;
                            period_of[i] = c.period;
                            count_of[i]  = '0;
                            word_of[i]   = c.message_word;
                            got          = i + 1;
                        end
                    end
                    r.kind = KIND_REPLY;
                    r.slot = HANDLE_W'(got);
                    r.last = 1'b1;
                    due_results.push_back(r);
                end
                OP_DESTROY:
                begin
                    if (c.slot_handle >= 1 && c.slot_handle <= SLOTS)
                        owner_of[c.slot_handle - 1] = '0;
                end
                default: ;
            endcase
        endfunction

        // compare one strobed result with the oldest one due
        function void check_result(input ptst_res_t seen);
            ptst_res_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with none due: kind %0d slot %0d owner %h value %h last %0d",
                             $time, seen.kind, seen.slot, seen.owner_out, seen.value, seen.last);
                return;
            end
            want = due_results.pop_front();
            if (seen.kind != want.kind || seen.slot != want.slot ||
                seen.owner_out != want.owner_out || seen.value != want.value ||
                seen.last != want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result mismatch: expected kind %0d slot %0d owner %h value %h last %0d, got kind %0d slot %0d owner %h value %h last %0d",
                             $time, want.kind, want.slot, want.owner_out, want.value, want.last,
                             seen.kind, seen.slot, seen.owner_out, seen.value, seen.last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     operation;
    logic [OWNER_W-1:0]  owner;
    logic [WORD_W-1:0]   period;
    logic [WORD_W-1:0]   message_word;
    logic [HANDLE_W-1:0] slot_handle;
    logic                strobe;
    logic                kind;
    logic [HANDLE_W-1:0] slot;
    logic [OWNER_W-1:0]  owner_out;
    logic [WORD_W-1:0]   value;
    logic                last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    slot_table_tracker   tracker = new();
    int unsigned         cycles = 0;
    // clear to hold the sender without gaps for a whole stretch
    bit                  gaps_on = 1'b1;

    always #4 clk = ~clk;

    periodic_timer_slot_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .owner        (owner),
        .period       (period),
        .message_word (message_word),
        .slot_handle  (slot_handle),
        .strobe       (strobe),
        .kind         (kind),
        .slot         (slot),
        .owner_out    (owner_out),
        .value        (value),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------------
    // Monitor: check results first, then note the item taken at this edge.
    // Results due from earlier items stay ahead of it in the queue.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            tracker.check_result({1'b1, kind, slot, owner_out, value, last});
        if (rst_n && start && !busy)
            tracker.note_item({operation, owner, period, message_word, slot_handle});
    end

    // watchdog: end a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // present one item and hold it until the block takes it; start is left
    // high so that the next item can follow at once
    task automatic send_item(input logic [OP_W-1:0]     op,
                             input logic [OWNER_W-1:0]  own,
                             input logic [WORD_W-1:0]   per,
                             input logic [WORD_W-1:0]   wrd,
                             input logic [HANDLE_W-1:0] hnd);
        if (gaps_on && $urandom_range(99) < 6)
        begin
            // drop start for a while; long gaps also reach the idle block
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        owner        <= own;
        period       <= per;
        message_word <= wrd;
        slot_handle  <= hnd;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // tick with noise in the fields the block does not use
    task automatic send_tick();
        send_item(OP_TICK, OWNER_W'($urandom), $urandom, $urandom, HANDLE_W'($urandom));
    endtask

    // create with a period scaled to the tick length, so that slots expire
    // within a few ticks; some periods are zero or anywhere in the range
    task automatic send_random_create(input logic [TICK_W-1:0] ms, input bit allow_free);
        logic [OWNER_W-1:0] own;
        logic [WORD_W-1:0]  per;
        logic [WORD_W-1:0]  wrd;
        int                 pick;
        if (allow_free && $urandom_range(99) < 5)
            own = '0;
        else
            own = OWNER_W'($urandom_range(1, 65535));
        pick = $urandom_range(99);
        if (pick < 15)
            per = $urandom;
        else if (pick < 25)
            per = '0;
        else
            per = WORD_W'(ms * $urandom_range(0, 6) + $urandom_range(0, ms));
        wrd = ($urandom_range(99) < 35) ? '0 : WORD_W'($urandom);
        send_item(OP_CREATE, own, per, wrd, HANDLE_W'($urandom));
    endtask

    // mostly handles in range, some outside it
    task automatic send_random_destroy();
        logic [HANDLE_W-1:0] hnd;
        if ($urandom_range(99) < 85)
            hnd = HANDLE_W'($urandom_range(1, SLOTS));
        else
            hnd = HANDLE_W'($urandom_range(0, 63));
        send_item(OP_DESTROY, OWNER_W'($urandom), $urandom, $urandom, hnd);
    endtask

    task automatic send_random_item(input logic [TICK_W-1:0] ms);
        int pick;
        pick = $urandom_range(99);
        if (pick < 38)
            send_tick();
        else if (pick < 72)
            send_random_create(ms, 1'b1);
        else if (pick < 96)
            send_random_destroy();
        else
            send_item(OP_UNUSED, OWNER_W'($urandom), $urandom, $urandom, HANDLE_W'($urandom));
    endtask

    // drop start, wait for every due result, then let the block go idle
    task automatic settle_table();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of the tick length: setup cycle, then access cycle
    task automatic write_tick_length(input logic [TICK_W-1:0] ms);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'({REG_TICK_LENGTH, 2'b00});
        pwdata  <= 32'(ms);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_tick(ms);
    endtask

    // settle, set the tick length and run a stretch of random items
    task automatic run_phase(input logic [TICK_W-1:0] ms, input int n_items);
        settle_table();
        write_tick_length(ms);
        repeat (n_items) send_random_item(ms);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_TICK;
        owner        = '0;
        period       = '0;
        message_word = '0;
        slot_handle  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick on an empty table: no result
        send_tick();
        // extremes of owner, period and word; an owner of zero takes slot 2
        // but leaves it free, so the next create gets slot 2 again
        send_item(OP_CREATE, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
        send_item(OP_CREATE, 16'h0000, 32'd5, 32'h0000_0000, 6'd0);
        send_item(OP_CREATE, 16'h0001, 32'd200, 32'h0000_0000, 6'd0);
        send_item(OP_CREATE, 16'h8000, 32'hFFFF_FFFF, 32'h1234_5678, 6'd0);
        send_item(OP_CREATE, 16'h5A5A, 32'd300, 32'hA5A5_A5A5, 6'd0);
        // period zero expires every tick; zero words report the count
        repeat (4) send_tick();
        // handles out of range and the spare code are ignored
        send_item(OP_DESTROY, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        send_item(OP_DESTROY, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd33);
        send_item(OP_DESTROY, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_DESTROY, 16'h0000, 32'h0, 32'h0, 6'd1);
        send_tick();
        send_item(OP_DESTROY, 16'h0000, 32'h0, 32'h0, 6'd4);
        send_item(OP_DESTROY, 16'h0000, 32'h0, 32'h0, 6'd2);
        send_item(OP_DESTROY, 16'h0000, 32'h0, 32'h0, 6'd3);

        // zero tick length: only the slot with period zero expires
        settle_table();
        write_tick_length(16'd0);
        send_item(OP_CREATE, 16'h0002, 32'd0, 32'h0, 6'd0);
        send_item(OP_CREATE, 16'h0003, 32'd1, 32'd77, 6'd0);
        send_tick();
        send_tick();
        send_item(OP_DESTROY, 16'h0, 32'h0, 32'h0, 6'd1);
        send_item(OP_DESTROY, 16'h0, 32'h0, 32'h0, 6'd2);

        // shortest nonzero tick length
        run_phase(16'd1, 20);

        // longest tick length with a full table: replies of zero once full,
        // then ticks with many expiries each
        settle_table();
        write_tick_length(16'hFFFF);
        repeat (SLOTS + 2) send_random_create(16'hFFFF, 1'b0);
        repeat (3) send_tick();
        repeat (14) send_random_destroy();
        repeat (2) send_tick();

        // a stretch with no gaps at all
        gaps_on = 1'b0;
        run_phase(TICK_W'($urandom_range(1, 65535)), 20);
        gaps_on = 1'b1;

        run_phase(TICK_LENGTH_RESET, 20);
        run_phase(16'hFFFF, 11);
        run_phase(TICK_W'($urandom_range(1, 65535)), 11);

        settle_table();
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/ptst_pkg.sv
src/ptst_engine.sv
src/periodic_timer_slot_table_top.sv
src/ptst_checker.sv
tb/periodic_timer_slot_table_top_test.sv
